/* design/soop_pkg.sv */
// ----------------------------------------------------------------------------
// soop_pkg
// Shared constants and types for the COM device-name option parser.
// ----------------------------------------------------------------------------
package soop_pkg;

	localparam logic [1:0] PH_PREFIX = 2'd0;
	localparam logic [1:0] PH_PORT   = 2'd1;
	localparam logic [1:0] PH_OPTS   = 2'd2;

	localparam logic [1:0] V_UNDECIDED = 2'd0;
	localparam logic [1:0] V_NOTCOM    = 2'd1;
	localparam logic [1:0] V_ERROR     = 2'd2;

	localparam logic [1:0] ST_NOTCOM = 2'd0;
	localparam logic [1:0] ST_ERROR  = 2'd1;
	localparam logic [1:0] ST_VALID  = 2'd2;

	localparam logic [23:0] KW_RS  = 24'd21330;
	localparam logic [23:0] KW_BIN = 24'd5130562;
	localparam logic [23:0] KW_ASC = 24'd4412225;
	localparam logic [23:0] KW_TB  = 24'd16980;
	localparam logic [23:0] KW_RB  = 24'd16978;
	localparam logic [23:0] KW_LF  = 24'd17996;
	localparam logic [23:0] KW_CD  = 24'd17475;
	localparam logic [23:0] KW_CS  = 24'd21315;
	localparam logic [23:0] KW_DS  = 24'd21316;
	localparam logic [23:0] KW_OP  = 24'd20559;
	localparam logic [23:0] KW_PE  = 24'd17744;

	localparam logic [30:0] NUM_MAX = 31'd2147483647;

	// parsed settings plus per-option flags
	typedef struct packed {
		logic [30:0] baud;
		logic [2:0]  parity;
		logic [3:0]  bits;
		logic [4:0]  stop;
		logic        rs;
		logic        binasc_set;
		logic        asc;
		logic        lf;
		logic        cd_set;
		logic        cs_set;
		logic        ds_set;
		logic        op_set;
		logic        tb;
		logic        rb;
		logic [15:0] cd;
		logic [15:0] cs;
		logic [15:0] ds;
		logic [15:0] op;
	} settings_t;

	// result item
	typedef struct packed {
		logic [15:0] op_timeout;
		logic [15:0] ds_timeout;
		logic [15:0] cs_timeout;
		logic [15:0] cd_timeout;
		logic [2:0]  mode_flags;
		logic [4:0]  stop_tenths;
		logic [3:0]  data_bits;
		logic [2:0]  parity_mode;
		logic [30:0] baud;
		logic [7:0]  port_number;
		logic [1:0]  status;
	} result_t;

	function automatic logic [4:0] stop_default(input logic [30:0] baud,
			input logic [3:0] bits);
		logic [4:0] x;
		x = 5'd10;
		if (baud <= 31'd110) begin
			x = (bits == 4'd5) ? 5'd15 : 5'd20;
		end
		return x;
	endfunction

endpackage

/* design/soop_core.sv */
// ----------------------------------------------------------------------------
// soop_core
// Per-byte parser state update and result formation for one registered item.
// ----------------------------------------------------------------------------
module soop_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,       // registered item present
	input  logic [7:0]          c_in,
	input  logic                last,
	output logic                res_vld,
	output soop_pkg::result_t   res
);

	logic [1:0]           phase_q, verdict_q;
	logic [1:0]           cnt_q;
	logic [8:0]           port_q;
	logic [2:0]           stage_q;
	logic [23:0]          text_q;
	logic                 omit_q, zero_q, nmode_q;
	logic [30:0]          num_q;
	soop_pkg::settings_t  s_q;

	logic [1:0]           phase_d, verdict_d, cnt_d;
	logic [8:0]           port_d;
	logic [2:0]           stage_d;
	logic [23:0]          text_d;
	logic                 omit_d, zero_d, nmode_d;
	logic [30:0]          num_d;
	soop_pkg::settings_t  s_d;

	logic [7:0]           c;
	logic [7:0]           pfx;
	logic [12:0]          pnv;
	logic                 ok, close;
	logic [34:0]          nv;
	logic [31:0]          v;       // closed token value
	logic                 v_omit;
	logic [23:0]          t;
	logic                 cok;
	logic [19:0]          cd10, ds10, opv;
	logic [1:0]           vfin;

	// timeout option check
	function automatic logic tmo_ok(input logic set, input logic vo,
			input logic [31:0] vv);
		return !set && (vo || vv <= 32'd65535);
	endfunction

	always_comb begin
		phase_d = phase_q; verdict_d = verdict_q; cnt_d = cnt_q; port_d = port_q;
		stage_d = stage_q; text_d = text_q; omit_d = omit_q; zero_d = zero_q;
		nmode_d = nmode_q; num_d = num_q; s_d = s_q;
		ok = 1'b1; cok = 1'b1; close = 1'b0;
		nv = '0; v = '0; v_omit = 1'b0; t = '0;
		pnv = '0;
		c = c_in;
		unique case (cnt_q)
			2'd0:    pfx = 8'd67;
			2'd1:    pfx = 8'd79;
			default: pfx = 8'd77;
		endcase
		if (verdict_q == soop_pkg::V_UNDECIDED) begin
			if (phase_q == soop_pkg::PH_PREFIX) begin
				if ((c_in & 8'd223) != pfx) verdict_d = soop_pkg::V_NOTCOM;
				else if (cnt_q == 2'd2) phase_d = soop_pkg::PH_PORT;
				else cnt_d = cnt_q + 2'd1;
			end else if (phase_q == soop_pkg::PH_PORT) begin
				if (c_in == 8'd58) begin
					if (port_q == 9'd0 || port_q > 9'd255) verdict_d = soop_pkg::V_ERROR;
					else phase_d = soop_pkg::PH_OPTS;
				end else if (c_in < 8'd48 || c_in > 8'd57) begin
					verdict_d = soop_pkg::V_NOTCOM;
				end else if (port_q == 9'd0 && c_in == 8'd48) begin
					verdict_d = soop_pkg::V_NOTCOM;
				end else begin
					pnv = {port_q, 3'b000} + {3'b000, port_q, 1'b0} + {9'd0, c_in[3:0]};
					port_d = (pnv > 13'd256) ? 9'd256 : pnv[8:0];
				end
			end else begin
				// option character
				if (c_in >= 8'd97 && c_in <= 8'd122) c = c_in - 8'd32;
				if (c != 8'd44) begin
					if (c < 8'd48 || (c > 8'd57 && c < 8'd65) || c > 8'd90) ok = 1'b0;
					else if (nmode_q && c >= 8'd65) ok = 1'b0;
					else begin
						if (c < 8'd65) nmode_d = 1'b1;
						if (!nmode_d || stage_q == 3'd4) begin
							if (text_q[23:16] != 8'd0) ok = 1'b0;
							else if (text_q[15:8] != 8'd0) text_d[23:16] = c;
							else if (text_q[7:0] != 8'd0) text_d[15:8] = c;
							else text_d = {16'd0, c};
						end else begin
							if (zero_q) ok = 1'b0;
							else if (c > 8'd48) begin
								nv = {num_q, 3'b000} + {3'b000, num_q, 1'b0}
									+ {31'd0, c[3:0]} - 35'd0;
								if (omit_q) nv = {31'd0, c[3:0]};
								if (nv > {4'd0, soop_pkg::NUM_MAX}) ok = 1'b0;
								num_d = nv[30:0]; omit_d = 1'b0;
							end else begin
								if (omit_q) begin
									zero_d = 1'b1; omit_d = 1'b0; num_d = '0;
								end else begin
									nv = {num_q, 3'b000} + {3'b000, num_q, 1'b0};
									if (nv > {4'd0, soop_pkg::NUM_MAX}) ok = 1'b0;
									num_d = nv[30:0];
								end
							end
						end
					end
				end
				close = ok && (c == 8'd44 || last);
				if (!ok) verdict_d = soop_pkg::V_ERROR;
				if (close) begin
					t = text_d;
					v_omit = omit_d;
					v = {1'b0, num_d};
					case (stage_q)
						3'd1: begin
							if (t != 24'd0 || (!v_omit && v == 32'd0)) cok = 1'b0;
							else s_d.baud = v_omit ? 31'd300 : v[30:0];
							stage_d = 3'd2;
						end
						3'd2: begin
							if (!v_omit) cok = 1'b0;
							else if (t == 24'd78) s_d.parity = 3'd0;
							else if (t == 24'd0 || t == 24'd69) s_d.parity = 3'd1;
							else if (t == 24'd79) s_d.parity = 3'd2;
							else if (t == 24'd83) s_d.parity = 3'd3;
							else if (t == 24'd77) s_d.parity = 3'd4;
							else if (t == soop_pkg::KW_PE) s_d.parity = 3'd5;
							else cok = 1'b0;
							stage_d = 3'd3;
						end
						3'd3: begin
							if (t != 24'd0) cok = 1'b0;
							else if (v_omit) s_d.bits = 4'd7;
							else if (v >= 32'd5 && v <= 32'd8) s_d.bits = v[3:0];
							else cok = 1'b0;
							stage_d = 3'd4;
						end
						3'd4: begin
							if (!v_omit) cok = 1'b0;
							else if (t == 24'd0)
								s_d.stop = soop_pkg::stop_default(s_q.baud, s_q.bits);
							else if (t == 24'd49) s_d.stop = 5'd10;
							else if (t == 24'd50) s_d.stop = 5'd20;
							else cok = 1'b0;
							stage_d = 3'd5;
						end
						default: begin
							if (t == 24'd0) cok = 1'b0;
							else if (t == soop_pkg::KW_RS) begin
								if (s_q.rs) cok = 1'b0; else s_d.rs = 1'b1;
							end else if (t == soop_pkg::KW_BIN || t == soop_pkg::KW_ASC) begin
								if (s_q.binasc_set) cok = 1'b0;
								else begin
									s_d.binasc_set = 1'b1;
									s_d.asc = (t == soop_pkg::KW_ASC);
								end
							end else if (t == soop_pkg::KW_TB) begin
								if (s_q.tb) cok = 1'b0; else s_d.tb = 1'b1;
							end else if (t == soop_pkg::KW_RB) begin
								if (s_q.rb) cok = 1'b0; else s_d.rb = 1'b1;
							end else if (t == soop_pkg::KW_LF) begin
								if (s_q.lf) cok = 1'b0; else s_d.lf = 1'b1;
							end else if (t == soop_pkg::KW_CD) begin
								cok = tmo_ok(s_q.cd_set, v_omit, v);
								if (cok) begin s_d.cd_set = 1'b1; s_d.cd = v_omit ? 16'd0 : v[15:0]; end
							end else if (t == soop_pkg::KW_CS) begin
								cok = tmo_ok(s_q.cs_set, v_omit, v);
								if (cok) begin s_d.cs_set = 1'b1; s_d.cs = v_omit ? 16'd1000 : v[15:0]; end
							end else if (t == soop_pkg::KW_DS) begin
								cok = tmo_ok(s_q.ds_set, v_omit, v);
								if (cok) begin s_d.ds_set = 1'b1; s_d.ds = v_omit ? 16'd1000 : v[15:0]; end
							end else if (t == soop_pkg::KW_OP) begin
								cok = tmo_ok(s_q.op_set, v_omit, v);
								if (cok) begin s_d.op_set = 1'b1; s_d.op = v_omit ? 16'd10000 : v[15:0]; end
							end else cok = 1'b0;
						end
					endcase
					text_d = '0; omit_d = 1'b1; zero_d = 1'b0; nmode_d = 1'b0; num_d = '0;
					if (!cok) verdict_d = soop_pkg::V_ERROR;
				end
			end
		end

		// result from next-state values
		vfin = verdict_d;
		if (vfin == soop_pkg::V_UNDECIDED && phase_d != soop_pkg::PH_OPTS)
			vfin = soop_pkg::V_NOTCOM;
		res = '0;
		cd10 = '0; ds10 = '0; opv = '0;
		if (vfin == soop_pkg::V_ERROR) begin
			res.status = soop_pkg::ST_ERROR;
		end else if (vfin == soop_pkg::V_UNDECIDED) begin
			res.status = soop_pkg::ST_VALID;
			res.port_number = port_d[7:0];
			res.baud = (stage_d <= 3'd1) ? 31'd300 : s_d.baud;
			res.parity_mode = (stage_d <= 3'd2) ? 3'd1 : s_d.parity;
			res.data_bits = (stage_d <= 3'd3) ? 4'd7 : s_d.bits;
			res.stop_tenths = (stage_d <= 3'd4) ?
				soop_pkg::stop_default(res.baud, res.data_bits) : s_d.stop;
			res.mode_flags = {s_d.lf & s_d.asc, s_d.asc, s_d.rs};
			res.cd_timeout = s_d.cd_set ? s_d.cd : 16'd0;
			res.cs_timeout = s_d.cs_set ? s_d.cs : 16'd1000;
			res.ds_timeout = s_d.ds_set ? s_d.ds : 16'd1000;
			cd10 = {1'b0, res.cd_timeout, 3'b000} + {3'b000, res.cd_timeout, 1'b0};
			ds10 = {1'b0, res.ds_timeout, 3'b000} + {3'b000, res.ds_timeout, 1'b0};
			opv = (ds10 > cd10) ? ds10 : cd10;
			res.op_timeout = s_d.op_set ? s_d.op :
				((opv > 20'd65535) ? 16'hFFFF : opv[15:0]);
		end else begin
			res.status = soop_pkg::ST_NOTCOM;
		end
	end

	assign res_vld = in_vld && last;

	// parser state; returns to reset after each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= soop_pkg::PH_PREFIX; verdict_q <= soop_pkg::V_UNDECIDED;
			cnt_q <= '0; port_q <= '0; stage_q <= 3'd1; text_q <= '0;
			omit_q <= 1'b1; zero_q <= 1'b0; nmode_q <= 1'b0; num_q <= '0; s_q <= '0;
		end else if (in_vld) begin
			if (last) begin
				phase_q <= soop_pkg::PH_PREFIX; verdict_q <= soop_pkg::V_UNDECIDED;
				cnt_q <= '0; port_q <= '0; stage_q <= 3'd1; text_q <= '0;
				omit_q <= 1'b1; zero_q <= 1'b0; nmode_q <= 1'b0; num_q <= '0; s_q <= '0;
			end else begin
				phase_q <= phase_d; verdict_q <= verdict_d; cnt_q <= cnt_d;
				port_q <= port_d; stage_q <= stage_d; text_q <= text_d;
				omit_q <= omit_d; zero_q <= zero_d; nmode_q <= nmode_d;
				num_q <= num_d; s_q <= s_d;
			end
		end
	end

endmodule

/* design/serial_open_option_parser.sv */
// ----------------------------------------------------------------------------
// serial_open_option_parser
// Parses a COM device name with options, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one character per item in s_axis_tdata, with
//   s_axis_tlast high on the final character (no terminator is sent).
//   The master channel carries one result per name, issued for the item
//   flagged last; other items produce nothing.
//   An accepted byte is held in an input register; from there the parser
//   updates its state and writes the result register, which drives
//   m_axis_tvalid. One byte per cycle is sustained unless s_axis_tready
//   is held low by a stall.
//   The single result register sits between the parser and the receiver:
//   while a result waits, s_axis_tready stays high unless a new last byte
//   would need the register, so a stalled receiver only stalls the input
//   when a second result is pending.
//   Reset clears the parser to the start of a name and empties both
//   registers.
// ----------------------------------------------------------------------------
module serial_open_option_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] name_byte
	input  logic         s_axis_tlast,   // is_last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [1:0] status, [9:2] port_number, [40:10] baud, [43:41] parity_mode,
	// [47:44] data_bits, [52:48] stop_tenths, [55:53] mode_flags,
	// [71:56] cd_timeout, [87:72] cs_timeout, [103:88] ds_timeout,
	// [119:104] op_timeout
	output logic [119:0] m_axis_tdata
);

	logic              vld_s1, last_s1;
	logic [7:0]        byte_s1;
	logic              res_vld;
	soop_pkg::result_t res;
	logic              out_vld_q;
	soop_pkg::result_t out_q;
	logic              stall;

	// stage 1 holds a last byte that cannot yet reach the output register
	assign stall = vld_s1 && last_s1 && out_vld_q && !m_axis_tready;
	assign s_axis_tready = !stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	soop_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1 && !stall),
		.c_in    (byte_s1),
		.last    (last_s1),
		.res_vld (res_vld),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_vld) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

endmodule

/* dv/soop_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soop_checker
// Watches both channels of the COM option parser, predicts the result for
// each name from the accepted bytes and compares every field in order.
// ----------------------------------------------------------------------------
module soop_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         s_axis_tlast,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [119:0] m_axis_tdata,
	output int           fail_count,
	output int           pending
);

	localparam longint TOK_OMIT = -1;
	localparam longint TOK_ZERO = -2;

	// predictor state
	logic [1:0]           ph;
	int                   pfx_cnt;
	int                   port_acc;
	int                   stage;
	logic [31:0]          tok_txt;
	longint               tok_num;
	logic                 num_mode;
	soop_pkg::settings_t  cfg;
	logic [1:0]           verd;
	soop_pkg::result_t    expected_results[$];

	function automatic logic [4:0] pick_stop();
		if (cfg.baud <= 110) return (cfg.bits == 5) ? 5'd15 : 5'd20;
		return 5'd10;
	endfunction

	function automatic void clear_name();
		ph = soop_pkg::PH_PREFIX;
		pfx_cnt = 0;
		port_acc = 0;
		stage = 1;
		tok_txt = 0;
		tok_num = TOK_OMIT;
		num_mode = 0;
		cfg = '0;
		verd = soop_pkg::V_UNDECIDED;
	endfunction

	function automatic bit apply_timeout(inout logic was_set, inout logic [15:0] dst,
			input longint v, input longint dflt);
		if (was_set) return 0;
		if (v == TOK_OMIT) v = dflt;
		if (v > 65535) return 0;
		was_set = 1;
		dst = v[15:0];
		return 1;
	endfunction

	// close one option; returns 0 on a syntax error
	function automatic bit finish_option();
		longint v;
		logic [31:0] t;
		bit ok;
		v = tok_num;
		t = tok_txt;
		ok = 1;
		if (v == TOK_ZERO) v = 0;
		case (stage)
			1: begin
				if (t != 0 || v == 0) return 0;
				cfg.baud = (v == TOK_OMIT) ? 31'd300 : v[30:0];
				stage = 2;
			end
			2: begin
				if (v != TOK_OMIT) return 0;
				if (t == "N") cfg.parity = 0;
				else if (t == 0 || t == "E") cfg.parity = 1;
				else if (t == "O") cfg.parity = 2;
				else if (t == "S") cfg.parity = 3;
				else if (t == "M") cfg.parity = 4;
				else if (t == soop_pkg::KW_PE) cfg.parity = 5;
				else return 0;
				stage = 3;
			end
			3: begin
				if (t != 0) return 0;
				if (v == TOK_OMIT) cfg.bits = 7;
				else if (v >= 5 && v <= 8) cfg.bits = v[3:0];
				else return 0;
				stage = 4;
			end
			4: begin
				if (v != TOK_OMIT) return 0;
				if (t == 0) cfg.stop = pick_stop();
				else if (t == "1") cfg.stop = 10;
				else if (t == "2") cfg.stop = 20;
				else return 0;
				stage = 5;
			end
			default: begin
				if (t == 0) return 0;
				if (t == soop_pkg::KW_RS) begin
					if (cfg.rs) return 0;
					cfg.rs = 1;
				end else if (t == soop_pkg::KW_BIN || t == soop_pkg::KW_ASC) begin
					if (cfg.binasc_set) return 0;
					cfg.binasc_set = 1;
					cfg.asc = (t == soop_pkg::KW_ASC);
				end else if (t == soop_pkg::KW_TB) begin
					if (cfg.tb) return 0;
					cfg.tb = 1;
				end else if (t == soop_pkg::KW_RB) begin
					if (cfg.rb) return 0;
					cfg.rb = 1;
				end else if (t == soop_pkg::KW_LF) begin
					if (cfg.lf) return 0;
					cfg.lf = 1;
				end else if (t == soop_pkg::KW_CD)
					ok = apply_timeout(cfg.cd_set, cfg.cd, v, 0);
				else if (t == soop_pkg::KW_CS)
					ok = apply_timeout(cfg.cs_set, cfg.cs, v, 1000);
				else if (t == soop_pkg::KW_DS)
					ok = apply_timeout(cfg.ds_set, cfg.ds, v, 1000);
				else if (t == soop_pkg::KW_OP)
					ok = apply_timeout(cfg.op_set, cfg.op, v, 10000);
				else return 0;
			end
		endcase
		tok_txt = 0;
		tok_num = TOK_OMIT;
		num_mode = 0;
		return ok;
	endfunction

	function automatic bit take_char(input logic [31:0] c);
		if (c >= "a" && c <= "z") c -= 32;
		if (c == ",") return 1;
		if (c < "0" || (c > "9" && c < "A") || c > "Z") return 0;
		if (num_mode && c >= "A") return 0;
		if (c < "A") num_mode = 1;
		if (!num_mode || stage == 4) begin
			if (tok_txt[23:16] != 0) return 0;
			if (tok_txt[15:8] != 0) tok_txt[23:16] = c[7:0];
			else if (tok_txt[7:0] != 0) tok_txt[15:8] = c[7:0];
			else tok_txt = c;
		end else begin
			if (tok_num == TOK_ZERO) return 0;
			if (c > "0") begin
				if (tok_num == TOK_OMIT) tok_num = 0;
				tok_num = tok_num * 10 + (c - "0");
			end else begin
				if (tok_num == TOK_OMIT) tok_num = TOK_ZERO;
				else if (tok_num > 0) tok_num *= 10;
			end
			if (tok_num > 2147483647) return 0;
		end
		return 1;
	endfunction

	// advance the predictor by one byte
	function automatic void parse_byte(input logic [7:0] c, input logic last);
		soop_pkg::result_t r;
		longint op;
		if (verd == soop_pkg::V_UNDECIDED) begin
			if (ph == soop_pkg::PH_PREFIX) begin
				if ((c & 8'd223) != 8'("COM" >> (8 * (2 - pfx_cnt))))
					verd = soop_pkg::V_NOTCOM;
				else begin
					pfx_cnt++;
					if (pfx_cnt >= 3) ph = soop_pkg::PH_PORT;
				end
			end else if (ph == soop_pkg::PH_PORT) begin
				if (c == ":") begin
					if (port_acc == 0 || port_acc > 255) verd = soop_pkg::V_ERROR;
					else ph = soop_pkg::PH_OPTS;
				end else if (c < "0" || c > "9") verd = soop_pkg::V_NOTCOM;
				else if (port_acc == 0 && c == "0") verd = soop_pkg::V_NOTCOM;
				else begin
					port_acc = port_acc * 10 + (c - "0");
					if (port_acc > 256) port_acc = 256;
				end
			end else begin
				if (!take_char(c)) verd = soop_pkg::V_ERROR;
				else if ((c == "," || last) && !finish_option()) verd = soop_pkg::V_ERROR;
			end
		end
		if (!last) return;
		r = '0;
		if (verd == soop_pkg::V_UNDECIDED && ph != soop_pkg::PH_OPTS)
			verd = soop_pkg::V_NOTCOM;
		if (verd == soop_pkg::V_NOTCOM) r.status = soop_pkg::ST_NOTCOM;
		else if (verd == soop_pkg::V_ERROR) r.status = soop_pkg::ST_ERROR;
		else begin
			if (stage <= 1) cfg.baud = 300;
			if (stage <= 2) cfg.parity = 1;
			if (stage <= 3) cfg.bits = 7;
			if (stage <= 4) cfg.stop = pick_stop();
			if (!cfg.cd_set) cfg.cd = 0;
			if (!cfg.cs_set) cfg.cs = 1000;
			if (!cfg.ds_set) cfg.ds = 1000;
			if (cfg.op_set) op = cfg.op;
			else begin
				op = longint'(cfg.cd) * 10;
				if (longint'(cfg.ds) * 10 > op) op = longint'(cfg.ds) * 10;
				if (op > 65535) op = 65535;
			end
			r.status = soop_pkg::ST_VALID;
			r.port_number = port_acc[7:0];
			r.baud = cfg.baud;
			r.parity_mode = cfg.parity;
			r.data_bits = cfg.bits;
			r.stop_tenths = cfg.stop;
			r.mode_flags = {cfg.lf & cfg.asc, cfg.asc, cfg.rs};
			r.cd_timeout = cfg.cd;
			r.cs_timeout = cfg.cs;
			r.ds_timeout = cfg.ds;
			r.op_timeout = op[15:0];
		end
		expected_results.push_back(r);
		clear_name();
	endfunction

	task automatic check_field(input string nm, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", nm, exp_v, act_v);
			fail_count++;
		end
	endtask

	assign pending = expected_results.size();

	initial begin
		fail_count = 0;
		clear_name();
	end

	always @(posedge clk) begin
		soop_pkg::result_t a, e;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				a = m_axis_tdata;
				if (expected_results.size() == 0) begin
					$error("unexpected result item, status %0d", a.status);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					check_field("status", e.status, a.status);
					check_field("port_number", e.port_number, a.port_number);
					check_field("baud", e.baud, a.baud);
					check_field("parity_mode", e.parity_mode, a.parity_mode);
					check_field("data_bits", e.data_bits, a.data_bits);
					check_field("stop_tenths", e.stop_tenths, a.stop_tenths);
					check_field("mode_flags", e.mode_flags, a.mode_flags);
					check_field("cd_timeout", e.cd_timeout, a.cd_timeout);
					check_field("cs_timeout", e.cs_timeout, a.cs_timeout);
					check_field("ds_timeout", e.ds_timeout, a.ds_timeout);
					check_field("op_timeout", e.op_timeout, a.op_timeout);
				end
			end
		end
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the COM option parser: directed names covering prefix, port
// and option corner cases, then random well-formed and broken names, with
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 0;
	logic         s_axis_tlast = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [119:0] m_axis_tdata;
	int           fail_count;
	int           pending;
	int           bytes_sent = 0;
	bit           calm = 0;
	bit           hold_rx = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	serial_open_option_parser DUT (.*);

	soop_checker u_checker (.*);

	// receiver: random stalls, one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) m_axis_tready <= 0;
			else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 4);
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
				m_axis_tready <= 1;
			end else m_axis_tready <= 1;
		end
	end

	// send one name byte by byte; tvalid stays up between names
	task automatic send_name(input string s);
		for (int i = 0; i < s.len(); i++) begin
			if (!calm && $urandom_range(0, 6) == 0) begin
				s_axis_tvalid <= 0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			s_axis_tvalid <= 1;
			s_axis_tdata <= s[i];
			s_axis_tlast <= (i == s.len() - 1);
			do @(posedge clk); while (!s_axis_tready);
			bytes_sent++;
		end
	endtask

	function automatic string rnd_case(input string s);
		for (int i = 0; i < s.len(); i++)
			if (s[i] >= "A" && s[i] <= "Z" && $urandom_range(0, 1)) s[i] = s[i] + 32;
		return s;
	endfunction

	function automatic string rnd_num(input int hi);
		return $sformatf("%0d", $urandom_range(0, hi));
	endfunction

	// mostly well-formed name with random content
	function automatic string make_name();
		string s;
		string pick[] = '{"RS", "BIN", "ASC", "TB", "RB", "LF", "CD", "CS", "DS", "OP"};
		string par[] = '{"", "N", "E", "O", "S", "M", "PE", "X"};
		int n;
		s = {"COM", rnd_num($urandom_range(0, 1) ? 9 : 300), ":"};
		if ($urandom_range(0, 5) == 0) return s;
		s = {s, $urandom_range(0, 3) == 0 ? "" :
			($urandom_range(0, 1) ? rnd_num(120) : rnd_num(32'hFFFF_FFFF))};
		s = {s, ",", par[$urandom_range(0, par.size() - 1)]};
		s = {s, ",", $urandom_range(0, 2) == 0 ? "" : rnd_num(9)};
		s = {s, ",", $urandom_range(0, 2) == 0 ? "" : rnd_num(3)};
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) begin
			string k;
			k = pick[$urandom_range(0, pick.size() - 1)];
			if ($urandom_range(0, 1)) k = {k, rnd_num($urandom_range(0, 1) ? 9999 : 70000)};
			s = {s, ",", k};
		end
		if ($urandom_range(0, 7) == 0) s = {s, ","};
		s = rnd_case(s);
		// occasional corruption or noise
		if ($urandom_range(0, 6) == 0) s[$urandom_range(0, s.len() - 1)] = $urandom_range(0, 255);
		if ($urandom_range(0, 15) == 0) begin
			s = "";
			repeat ($urandom_range(1, 10)) s = {s, string'(byte'($urandom_range(0, 255)))};
		end
		return s;
	endfunction

	initial begin
		string dir[] = '{
			"COM1:", "com255:9600,N,8,1", "CoM256:", "COM0:", "COM:", "CO", "X",
			"COM12", "COM1:1.5", "COM3:110,E,5,", "COM3:50,,,", "COM2:,PE,6,2,RS,ASC,LF",
			"COM4:2147483647,O,8,2,BIN,TB,RB,CD0,CS65535,DS7000,OP1",
			"COM4:2147483648", "COM5:0", "COM5:09", "COM5:9600,E,7,1,RS,RS",
			"COM5:1,M,5,,LF,BIN,ASC", "COM6:1,S,9", "COM6:1,,,3", "COM7:1,,,,CD65536",
			"COM7:1,,,,RS5,TB9,CD", "COM8:1,,,,ABCD", "COM9:1,,,,12A", "COM1:,,,,DS9,"};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir[i]) send_name(dir[i]);
		// long receiver hold-off while names keep flowing
		hold_rx = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end
			repeat (20) send_name(make_name());
		join
		while (bytes_sent < 1000) send_name(make_name());
		calm = 1;
		while (bytes_sent < 1150) send_name(make_name());
		send_name("COM1:");
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) $display("PASS serial_open_option_parser");
		else $display("FAIL serial_open_option_parser");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL serial_open_option_parser");
		$finish;
	end

endmodule

/* sim.f */
design/soop_pkg.sv
design/soop_core.sv
design/serial_open_option_parser.sv
dv/soop_checker.sv
dv/tb.sv
